// ----- rtl/dfm_pkg.sv -----
// ----------------------------------------------------------------------------
// dfm_pkg
// Shared types and constants for the escape/end byte-stuffing deframer.
// ----------------------------------------------------------------------------
package dfm_pkg;

    localparam int MAX_LEN_DEF = 256;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESYNC_MODE = 2'd2;

    localparam logic [7:0] ESCAPE_BYTE_RST = 8'h10;
    localparam logic [7:0] END_BYTE_RST    = 8'h03;
    localparam logic       RESYNC_MODE_RST = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_ID      = 3'd1,
        PH_IN      = 3'd2,
        PH_STUFF   = 3'd3,
        PH_ERR     = 3'd4,
        PH_ERR_ESC = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        K_ID    = 3'd0,
        K_DATA  = 3'd1,
        K_DONE  = 3'd2,
        K_FRERR = 3'd3,
        K_OVF   = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [8:0] count;
    } result_t;

    typedef struct packed {
        logic [7:0] escape_byte;
        logic [7:0] end_byte;
        logic       resync_mode;
    } cfg_t;

endpackage

// ----- rtl/dle_framed_packet_deframer_core.sv -----
// An accepted input beat goes from the input register through the state
// machine into the result register. Throughput: one input beat per cycle
// unless the output stalls; each byte takes a single pass of the machine.
// Reset: asynchronous, active low; clears phase, byte count, pipeline valids
// and restores escape 0x10, end 0x03, resync mode 1.
// ----------------------------------------------------------------------------
// dle_framed_packet_deframer_core
// Escape/end byte-stuffing deframer: input register, state machine, result
// register, configuration registers.
// ----------------------------------------------------------------------------
module dle_framed_packet_deframer_core
    import dfm_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            rx_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            kind,
    output logic [7:0]            data,
    output logic [8:0]            count
);

    cfg_t       cfg_reg;
    logic       in_v_reg;
    logic [7:0] in_byte_reg;
    logic       out_v_reg;
    result_t    out_reg;

    logic       out_load;
    logic       go;
    logic       res_valid;
    result_t    res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.escape_byte <= ESCAPE_BYTE_RST;
            cfg_reg.end_byte    <= END_BYTE_RST;
            cfg_reg.resync_mode <= RESYNC_MODE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ESCAPE_BYTE: cfg_reg.escape_byte <= cfg_data;
                CFG_END_BYTE:    cfg_reg.end_byte    <= cfg_data;
                CFG_RESYNC_MODE: cfg_reg.resync_mode <= cfg_data[0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign out_load = !out_v_reg || !out_stall;
    assign go       = in_v_reg && out_load;
    assign in_stall = in_v_reg && !out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    dfm_fsm #(
        .MAX_LEN (MAX_LEN)
    ) u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_v_reg <= go && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_v_reg;
    assign kind      = out_reg.kind;
    assign data      = out_reg.data;
    assign count     = out_reg.count;

endmodule

// ----- rtl/dfm_fsm.sv -----
// ----------------------------------------------------------------------------
// dfm_fsm
// Deframing state machine: phase and byte count, one received byte per beat,
// producing at most one result per beat.
// ----------------------------------------------------------------------------
module dfm_fsm
    import dfm_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       go,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output result_t    res
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);

    phase_t        phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [CW-1:0] base;
    logic [CW+8:0] pos_wide;
    logic          is_esc, is_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            cnt_reg   <= '0;
        end
        else if (go)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign is_esc   = (rx_byte == cfg.escape_byte);
    assign is_end   = (rx_byte == cfg.end_byte);
    assign base     = (phase_reg == PH_ID) ? '0 : cnt_reg;
    assign pos_wide = {9'd0, base};

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        res_valid  = 1'b0;
        res.kind   = K_DATA;
        res.data   = rx_byte;
        res.count  = pos_wide[8:0];
        case (phase_reg)
            PH_ID, PH_IN, PH_STUFF:
            begin
                if (phase_reg == PH_IN && is_esc)
                begin
                    phase_next = PH_STUFF;
                end
                else if (phase_reg == PH_STUFF && !is_esc && is_end)
                begin
                    res_valid  = 1'b1;
                    res.kind   = K_DONE;
                    res.data   = '0;
                    phase_next = PH_HUNT;
                    cnt_next   = '0;
                end
                else if ((phase_reg == PH_STUFF && !is_esc) || base >= MAX_CNT)
                begin
                    // framing error or overflow
                    res_valid  = 1'b1;
                    res.kind   = (phase_reg == PH_STUFF && !is_esc) ? K_FRERR : K_OVF;
                    res.data   = '0;
                    res.count  = '0;
                    phase_next = cfg.resync_mode ? PH_ERR : PH_HUNT;
                    cnt_next   = '0;
                end
                else
                begin
                    res_valid  = 1'b1;
                    res.kind   = (phase_reg == PH_ID) ? K_ID : K_DATA;
                    phase_next = PH_IN;
                    cnt_next   = base + 1'b1;
                end
            end
            PH_ERR:
            begin
                if (is_esc)
                begin
                    phase_next = PH_ERR_ESC;
                end
            end
            PH_ERR_ESC:
            begin
                phase_next = is_end ? PH_HUNT : PH_ERR;
            end
            default:
            begin
                cnt_next   = '0;
                phase_next = is_esc ? PH_ID : PH_HUNT;
            end
        endcase
    end

endmodule

// ----- dv/dle_framed_packet_deframer_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dle_framed_packet_deframer_core_tb
// Self-checking bench for the escape/end deframer. Byte streams of framed
// packets, broken frames, oversize packets and line noise are sent under
// random valid/stall gaps, across several escape/end/resync settings. A
// behavioral deframer tracks each accepted byte and queues the expected
// result beats, which the monitor compares field by field.
// ----------------------------------------------------------------------------
module dle_framed_packet_deframer_core_tb;
    import dfm_pkg::*;

    localparam int PKT_MAX = MAX_LEN_DEF;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            rx_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic [2:0]            kind;
    logic [7:0]            data;
    logic [8:0]            count;

    dle_framed_packet_deframer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data      (data),
        .count     (count)
    );

    // deframer state and register copies
    phase_t      ph;
    int unsigned stored;
    logic [7:0]  esc_val;
    logic [7:0]  end_val;
    logic        resync_val;

    logic [7:0]  pending_bytes[$];
    result_t     expected_results[$];
    result_t     exp_r;
    int unsigned queued_beats;
    int unsigned sent_beats;
    int unsigned errors;
    int unsigned cycle_cnt;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

    // random gaps, suppressed in a window that recurs with cycle_cnt
    function automatic bit take_break();
        return ((cycle_cnt % 1000) < 700) && ($urandom_range(99) < 36);
    endfunction

    function automatic void emit_result(kind_t k, logic [7:0] d, logic [8:0] c);
        result_t r;
        r.kind  = k;
        r.data  = d;
        r.count = c;
        expected_results.push_back(r);
    endfunction

    function automatic void abort_packet(kind_t k);
        ph     = resync_val ? PH_ERR : PH_HUNT;
        stored = 0;
        emit_result(k, 8'h00, 9'h000);
    endfunction

    function automatic void keep_byte(logic [7:0] ch, kind_t k);
        if (stored >= PKT_MAX)
            abort_packet(K_OVF);
        else
        begin
            emit_result(k, ch, 9'(stored));
            stored++;
            ph = PH_IN;
        end
    endfunction

    function automatic void deframe_step(logic [7:0] ch);
        case (ph)
            PH_ID:
            begin
                stored = 0;
                keep_byte(ch, K_ID);
            end
            PH_IN:
                if (ch == esc_val)
                    ph = PH_STUFF;
                else
                    keep_byte(ch, K_DATA);
            PH_STUFF:
                if (ch == esc_val)
                    keep_byte(ch, K_DATA);
                else if (ch == end_val)
                begin
                    emit_result(K_DONE, 8'h00, 9'(stored));
                    stored = 0;
                    ph     = PH_HUNT;
                end
                else
                    abort_packet(K_FRERR);
            PH_ERR:
                if (ch == esc_val)
                    ph = PH_ERR_ESC;
            PH_ERR_ESC:
                ph = (ch == end_val) ? PH_HUNT : PH_ERR;
            default:
            begin
                stored = 0;
                ph     = (ch == esc_val) ? PH_ID : PH_HUNT;
            end
        endcase
    endfunction

    // ---------------- stimulus builders ----------------
    function automatic void queue_byte(logic [7:0] b);
        pending_bytes.push_back(b);
        queued_beats++;
    endfunction

    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20)
            return esc_val;
        if (r < 32)
            return end_val;
        return 8'($urandom_range(255));
    endfunction

    function automatic void push_payload(logic [7:0] b);
        queue_byte(b);
        if (b == esc_val)
            queue_byte(b);
    endfunction

    function automatic void push_frame(int unsigned len);
        queue_byte(esc_val);
        queue_byte(pick_byte());
        repeat (len) push_payload(pick_byte());
        queue_byte(esc_val);
        queue_byte(end_val);
    endfunction

    function automatic void push_broken();
        logic [7:0] bad;
        queue_byte(esc_val);
        queue_byte(pick_byte());
        repeat ($urandom_range(0, 4)) push_payload(pick_byte());
        queue_byte(esc_val);
        do
            bad = 8'($urandom_range(255));
        while (bad == esc_val || bad == end_val);
        queue_byte(bad);
    endfunction

    function automatic void fill_random(int unsigned n);
        int unsigned goal;
        int unsigned r;
        goal = queued_beats + n;
        while (queued_beats < goal)
        begin
            r = $urandom_range(99);
            if (r < 2)
                push_frame($urandom_range(250, 258));
            else if (r < 62)
                push_frame($urandom_range(0, 12));
            else if (r < 80)
            begin
                push_broken();
                if ($urandom_range(1))
                begin
                    queue_byte(esc_val);
                    queue_byte(end_val);
                end
            end
            else if (r < 95)
                repeat ($urandom_range(1, 6)) queue_byte(pick_byte());
            else
            begin
                queue_byte(esc_val);
                queue_byte(pick_byte());
            end
        end
    endfunction

    // ---------------- sequencing ----------------
    task automatic wait_idle();
        do
            @(posedge clk);
        while (sent_beats != queued_beats || expected_results.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_ESCAPE_BYTE: esc_val    = val;
            CFG_END_BYTE:    end_val    = val;
            CFG_RESYNC_MODE: resync_val = val[0];
            default:         ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(logic [7:0] e, logic [7:0] n, logic m);
        wait_idle();
        write_reg(CFG_ESCAPE_BYTE, e);
        write_reg(CFG_END_BYTE, n);
        write_reg(CFG_RESYNC_MODE, {7'd0, m});
    endtask

    // ---------------- driver ----------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                deframe_step(rx_byte);
                sent_beats++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() != 0 && !take_break())
                begin
                    rx_byte  <= pending_bytes.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: extra beat: expected none, actual %0d/%0h/%0d",
                             $time, kind, data, count);
                    errors++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (kind !== exp_r.kind)
                    begin
                        $display("%0t: kind mismatch: expected %0d, actual %0d",
                                 $time, exp_r.kind, kind);
                        errors++;
                    end
                    if (data !== exp_r.data)
                    begin
                        $display("%0t: data mismatch: expected %0h, actual %0h",
                                 $time, exp_r.data, data);
                        errors++;
                    end
                    if (count !== exp_r.count)
                    begin
                        $display("%0t: count mismatch: expected %0d, actual %0d",
                                 $time, exp_r.count, count);
                        errors++;
                    end
                end
            end
            out_stall <= take_break();
        end
    end

    // ---------------- test sequence ----------------
    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        rx_byte      = 8'h00;
        out_stall    = 1'b0;
        cycle_cnt    = 0;
        queued_beats = 0;
        sent_beats   = 0;
        errors       = 0;
        ph           = PH_HUNT;
        stored       = 0;
        esc_val      = ESCAPE_BYTE_RST;
        end_val      = END_BYTE_RST;
        resync_val   = RESYNC_MODE_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: stuffed payload, id equal to escape, empty packet,
        // framing error with resync after a doubled escape
        queue_byte(8'h10); queue_byte(8'hFF); queue_byte(8'h00); queue_byte(8'h10);
        queue_byte(8'h10); queue_byte(8'h03); queue_byte(8'hFF); queue_byte(8'h10);
        queue_byte(8'h03);
        queue_byte(8'h10); queue_byte(8'h10); queue_byte(8'h10); queue_byte(8'h03);
        queue_byte(8'h10); queue_byte(8'h00); queue_byte(8'h10); queue_byte(8'h03);
        queue_byte(8'h10); queue_byte(8'h05); queue_byte(8'h10); queue_byte(8'h07);
        queue_byte(8'h10); queue_byte(8'h10); queue_byte(8'h10); queue_byte(8'h03);

        // full-length packet, then one byte past the limit
        push_frame(PKT_MAX - 1);
        push_frame(PKT_MAX);
        fill_random(30);
        // leave the block waiting on an error while the mode changes
        push_broken();

        set_config(8'h00, 8'hFF, 1'b0);
        fill_random(30);

        set_config(8'hFF, 8'h00, 1'b1);
        fill_random(30);

        // escape equal to end: frames cannot close
        begin
            logic [7:0] same;
            same = 8'($urandom_range(255));
            set_config(same, same, 1'b0);
            fill_random(20);
            wait_idle();
            write_reg(CFG_RESYNC_MODE, 8'h01);
            fill_random(15);
        end

        begin
            logic [7:0] e;
            logic [7:0] n;
            e = 8'($urandom_range(255));
            do
                n = 8'($urandom_range(255));
            while (n == e);
            set_config(e, n, 1'($urandom_range(1)));
            fill_random(25);
        end

        wait_idle();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- dle_framed_packet_deframer_core.f -----
rtl/dfm_pkg.sv
rtl/dfm_fsm.sv
rtl/dle_framed_packet_deframer_core.sv
dv/dle_framed_packet_deframer_core_tb.sv
